[rtl/core/nfpc_pkg.sv]
// Shared types, constants and fixed-point helpers for the Newton fractal pixel classifier.
package nfpc_pkg;

    localparam int IDX_W       = 10;
    localparam int COLOR_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int TDATA_W     = 24;
    localparam int DIV_STEPS   = 31;
    localparam int DIV_STAGES  = DIV_STEPS + 1;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    // sqrt(3)/2 with 30 fraction bits
    localparam longint SIN60_Q30 = 64'sd929887697;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_START = 3'd0,
        REG_Y_START = 3'd1,
        REG_X_STEP  = 3'd2,
        REG_Y_STEP  = 3'd3,
        REG_TOL_SQ  = 3'd4
    } cfg_reg_t;

    typedef enum logic [COLOR_W-1:0] {
        COLOR_NONE   = 3'd0,
        COLOR_ORIGIN = 3'd1,
        COLOR_UPPER  = 3'd2,
        COLOR_LOWER  = 3'd3,
        COLOR_ONE    = 3'd4
    } color_t;

    typedef struct packed {
        logic             valid;
        logic             zero_den;   // sticky over all iterations
        logic             den_zero;   // this iteration only
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
    } meta_t;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } cplx_t;

    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        if (v > 80'sd2147483647)
            return Q_MAX;
        if (v < -80'sd2147483648)
            return Q_MIN;
        return v[31:0];
    endfunction

    // round half up, floor shift
    function automatic logic signed [79:0] qround(input logic signed [63:0] p, input int f);
        logic signed [79:0] t;
        t = 80'(p) + (80'sd1 <<< (f - 1));
        return t >>> f;
    endfunction

endpackage

[rtl/core/nfpc_start.sv]
// Start point stage: z = start + index * step, two register stages.
module nfpc_start
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  nfpc_pkg::meta_t       in_meta,
    input  logic signed [31:0]    x_start,
    input  logic signed [31:0]    y_start,
    input  logic [30:0]           x_step,
    input  logic [30:0]           y_step,
    output nfpc_pkg::meta_t       out_meta,
    output nfpc_pkg::cplx_t       out_z
);
    import nfpc_pkg::*;

    meta_t       m1_reg, m2_reg;
    logic [40:0] px_reg, py_reg;
    cplx_t       z_reg, z_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_reg <= '0;
            m2_reg <= '0;
        end
        else if (en)
        begin
            m1_reg <= in_meta;
            m2_reg <= m1_reg;
        end
    end

    always_comb
    begin
        z_next.re = sat32({{48{x_start[31]}}, x_start} + {39'd0, px_reg});
        z_next.im = sat32({{48{y_start[31]}}, y_start} + {39'd0, py_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= 41'(in_meta.column) * 41'(x_step);
            py_reg <= 41'(in_meta.row) * 41'(y_step);
            z_reg  <= z_next;
        end
    end

    assign out_meta = m2_reg;
    assign out_z    = z_reg;

endmodule

[rtl/core/nfpc_div.sv]
// Pipelined restoring divider: signed Q(2F)/Q(2F) to saturated Q(F), one quotient bit per stage.
module nfpc_div #(
    parameter int FRAC_BITS = 24
)
(
    input  logic               clk,
    input  logic               en,
    input  logic               neg,
    input  logic [63:0]        mag,
    input  logic [63:0]        den,
    output logic signed [31:0] quo
);
    import nfpc_pkg::*;

    localparam int PRE = 31 - FRAC_BITS;

    logic [63:0]          rem_reg [0:DIV_STEPS];
    logic [63:0]          mag_reg [0:DIV_STEPS];
    logic [63:0]          den_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg   [0:DIV_STEPS];
    logic                 neg_reg [0:DIV_STEPS];
    logic                 ovf_reg [0:DIV_STEPS];

    // quotient would reach 2^31: saturate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= mag >> PRE;
            mag_reg[0] <= mag;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= {{PRE{1'b0}}, mag} >= {den, {PRE{1'b0}}};
        end
    end

    for (genvar s = 1; s <= DIV_STEPS; s++)
    begin : g_step
        localparam int J = DIV_STEPS - s;
        logic        nbit;
        logic [64:0] trial;
        logic        take;

        if (J >= FRAC_BITS)
        begin : g_mag
            assign nbit = mag_reg[s-1][J-FRAC_BITS];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        assign trial = {rem_reg[s-1], nbit};
        assign take  = trial >= {1'b0, den_reg[s-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= take ? 64'(trial - {1'b0, den_reg[s-1]}) : trial[63:0];
                mag_reg[s] <= mag_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                q_reg[s]   <= q_reg[s-1] | (DIV_STEPS'(take) << J);
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    always_comb
    begin
        if (ovf_reg[DIV_STEPS])
            quo = neg_reg[DIV_STEPS] ? Q_MIN : Q_MAX;
        else if (neg_reg[DIV_STEPS])
            quo = -$signed({1'b0, q_reg[DIV_STEPS]});
        else
            quo = $signed({1'b0, q_reg[DIV_STEPS]});
    end

endmodule

[rtl/core/nfpc_iter.sv]
// One Newton step z <- 9 z^4 / (5 z^6 + 2 z^3 + 2), fully pipelined.
module nfpc_iter #(
    parameter int FRAC_BITS = 24
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  nfpc_pkg::meta_t in_meta,
    input  nfpc_pkg::cplx_t in_z,
    output nfpc_pkg::meta_t out_meta,
    output nfpc_pkg::cplx_t out_z
);
    import nfpc_pkg::*;

    localparam int FRONT = 9;

    meta_t m_reg  [1:FRONT];
    meta_t dl_reg [0:DIV_STAGES-1];
    meta_t out_meta_reg;
    meta_t front_meta;

    // stage payloads
    cplx_t              z1_reg, zb2_reg, zb3_reg, zb4_reg;
    logic signed [63:0] p1_rr_reg, p1_ii_reg, p1_ri_reg;
    cplx_t              z2_reg;
    logic signed [63:0] p3_a_reg, p3_b_reg, p3_c_reg, p3_d_reg;
    cplx_t              z3_reg, z3_5_reg, z3_6_reg;
    logic signed [63:0] p5_a_reg, p5_b_reg, p5_c_reg, p5_d_reg;
    logic signed [63:0] p5_rr_reg, p5_ii_reg, p5_ri_reg;
    cplx_t              z4_reg, z6_reg, z4_7_reg;
    cplx_t              d7_reg;
    logic signed [63:0] p8_dr_reg, p8_di_reg, p8_a_reg, p8_b_reg, p8_c_reg, p8_d_reg;
    logic               dz8_reg;
    logic [63:0]        den9_reg, mr9_reg, mi9_reg;
    logic               nr9_reg, ni9_reg;
    cplx_t              z_out_reg;

    cplx_t              z2_next, z3_next, z4_next, z6_next, d7_next, z_out_next;
    logic signed [64:0] num_r, num_i;
    logic signed [31:0] q_re, q_im, qv_re, qv_im;

    // zero-denominator flags join the metadata as it enters the divider
    always_comb
    begin
        front_meta          = m_reg[FRONT-1];
        front_meta.den_zero = dz8_reg;
        front_meta.zero_den = m_reg[FRONT-1].zero_den | dz8_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= FRONT; k++)
                m_reg[k] <= '0;
            for (int k = 0; k < DIV_STAGES; k++)
                dl_reg[k] <= '0;
            out_meta_reg <= '0;
        end
        else if (en)
        begin
            m_reg[1] <= in_meta;
            for (int k = 2; k < FRONT; k++)
                m_reg[k] <= m_reg[k-1];
            m_reg[FRONT] <= front_meta;
            dl_reg[0] <= m_reg[FRONT];
            for (int k = 1; k < DIV_STAGES; k++)
                dl_reg[k] <= dl_reg[k-1];
            out_meta_reg <= dl_reg[DIV_STAGES-1];
        end
    end

    always_comb
    begin
        z2_next.re = sat32(qround(p1_rr_reg, FRAC_BITS) - qround(p1_ii_reg, FRAC_BITS));
        z2_next.im = sat32(qround(p1_ri_reg, FRAC_BITS) + qround(p1_ri_reg, FRAC_BITS));
        z3_next.re = sat32(qround(p3_a_reg, FRAC_BITS) - qround(p3_b_reg, FRAC_BITS));
        z3_next.im = sat32(qround(p3_c_reg, FRAC_BITS) + qround(p3_d_reg, FRAC_BITS));
        z4_next.re = sat32(qround(p5_a_reg, FRAC_BITS) - qround(p5_b_reg, FRAC_BITS));
        z4_next.im = sat32(qround(p5_c_reg, FRAC_BITS) + qround(p5_d_reg, FRAC_BITS));
        z6_next.re = sat32(qround(p5_rr_reg, FRAC_BITS) - qround(p5_ii_reg, FRAC_BITS));
        z6_next.im = sat32(qround(p5_ri_reg, FRAC_BITS) + qround(p5_ri_reg, FRAC_BITS));
        d7_next.re = sat32(80'(z6_reg.re) * 80'sd5 + 80'(z3_6_reg.re) * 80'sd2
                           + (80'sd2 <<< FRAC_BITS));
        d7_next.im = sat32(80'(z6_reg.im) * 80'sd5 + 80'(z3_6_reg.im) * 80'sd2);
        num_r = 65'(p8_a_reg) + 65'(p8_b_reg);
        num_i = 65'(p8_c_reg) - 65'(p8_d_reg);
        qv_re = dl_reg[DIV_STAGES-1].den_zero ? Q_MAX : q_re;
        qv_im = dl_reg[DIV_STAGES-1].den_zero ? Q_MAX : q_im;
        z_out_next.re = sat32(80'(qv_re) * 80'sd9);
        z_out_next.im = sat32(80'(qv_im) * 80'sd9);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // z^2
            p1_rr_reg <= 64'(in_z.re) * 64'(in_z.re);
            p1_ii_reg <= 64'(in_z.im) * 64'(in_z.im);
            p1_ri_reg <= 64'(in_z.re) * 64'(in_z.im);
            z1_reg    <= in_z;
            z2_reg    <= z2_next;
            zb2_reg   <= z1_reg;
            // z^3
            p3_a_reg  <= 64'(z2_reg.re) * 64'(zb2_reg.re);
            p3_b_reg  <= 64'(z2_reg.im) * 64'(zb2_reg.im);
            p3_c_reg  <= 64'(z2_reg.re) * 64'(zb2_reg.im);
            p3_d_reg  <= 64'(z2_reg.im) * 64'(zb2_reg.re);
            zb3_reg   <= zb2_reg;
            z3_reg    <= z3_next;
            zb4_reg   <= zb3_reg;
            // z^4 and z^6
            p5_a_reg  <= 64'(z3_reg.re) * 64'(zb4_reg.re);
            p5_b_reg  <= 64'(z3_reg.im) * 64'(zb4_reg.im);
            p5_c_reg  <= 64'(z3_reg.re) * 64'(zb4_reg.im);
            p5_d_reg  <= 64'(z3_reg.im) * 64'(zb4_reg.re);
            p5_rr_reg <= 64'(z3_reg.re) * 64'(z3_reg.re);
            p5_ii_reg <= 64'(z3_reg.im) * 64'(z3_reg.im);
            p5_ri_reg <= 64'(z3_reg.re) * 64'(z3_reg.im);
            z3_5_reg  <= z3_reg;
            z4_reg    <= z4_next;
            z6_reg    <= z6_next;
            z3_6_reg  <= z3_5_reg;
            // denominator
            d7_reg    <= d7_next;
            z4_7_reg  <= z4_reg;
            // n * conj(d) and |d|^2
            p8_dr_reg <= 64'(d7_reg.re) * 64'(d7_reg.re);
            p8_di_reg <= 64'(d7_reg.im) * 64'(d7_reg.im);
            p8_a_reg  <= 64'(z4_7_reg.re) * 64'(d7_reg.re);
            p8_b_reg  <= 64'(z4_7_reg.im) * 64'(d7_reg.im);
            p8_c_reg  <= 64'(z4_7_reg.im) * 64'(d7_reg.re);
            p8_d_reg  <= 64'(z4_7_reg.re) * 64'(d7_reg.im);
            dz8_reg   <= (d7_reg.re == 32'sd0) && (d7_reg.im == 32'sd0);
            den9_reg  <= 64'(p8_dr_reg) + 64'(p8_di_reg);
            nr9_reg   <= num_r[64];
            ni9_reg   <= num_i[64];
            mr9_reg   <= num_r[64] ? 64'(-num_r) : num_r[63:0];
            mi9_reg   <= num_i[64] ? 64'(-num_i) : num_i[63:0];
            z_out_reg <= z_out_next;
        end
    end

    nfpc_div #(.FRAC_BITS(FRAC_BITS)) u_div_re
    (
        .clk (clk),
        .en  (en),
        .neg (nr9_reg),
        .mag (mr9_reg),
        .den (den9_reg),
        .quo (q_re)
    );

    nfpc_div #(.FRAC_BITS(FRAC_BITS)) u_div_im
    (
        .clk (clk),
        .en  (en),
        .neg (ni9_reg),
        .mag (mi9_reg),
        .den (den9_reg),
        .quo (q_im)
    );

    assign out_meta = out_meta_reg;
    assign out_z    = z_out_reg;

endmodule

[rtl/core/nfpc_class.sv]
// Root classifier: squared distance to 0, the two complex cube roots and 1; three stages.
module nfpc_class #(
    parameter int FRAC_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  nfpc_pkg::meta_t              in_meta,
    input  nfpc_pkg::cplx_t              in_z,
    input  logic [30:0]                  tol_sq,
    output logic                         out_valid,
    output logic [nfpc_pkg::IDX_W-1:0]   out_column,
    output logic [nfpc_pkg::IDX_W-1:0]   out_row,
    output nfpc_pkg::color_t             out_color
);
    import nfpc_pkg::*;

    localparam longint SIN_Q  = (SIN60_Q30 + ((64'sd1 <<< (30 - FRAC_BITS)) >>> 1))
                                >>> (30 - FRAC_BITS);
    localparam logic signed [33:0] HALF = 34'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [33:0] ONE  = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] SIN  = 34'(SIN_Q);
    localparam logic signed [33:0] PT_RE [4] = '{34'sd0, -HALF, -HALF, ONE};
    localparam logic signed [33:0] PT_IM [4] = '{34'sd0, SIN, -SIN, 34'sd0};
    localparam logic signed [33:0] LIM  = 34'sd2147483647;

    meta_t       m1_reg, m2_reg;
    logic        v3_reg;
    logic [30:0] ax_reg [4];
    logic [30:0] ay_reg [4];
    logic [3:0]  ok1_reg, ok2_reg;
    logic [61:0] sx_reg [4];
    logic [61:0] sy_reg [4];
    logic [IDX_W-1:0] col3_reg, row3_reg;
    color_t      color3_reg, color_next;

    logic signed [33:0] dx [4];
    logic signed [33:0] dy [4];
    logic [3:0]         ok_next;
    logic [3:0]         hit;
    logic [62:0]        ssum [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dx[i] = 34'(in_z.re) - PT_RE[i];
            dy[i] = 34'(in_z.im) - PT_IM[i];
            ok_next[i] = (dx[i] <= LIM) && (dx[i] >= -LIM) && (dy[i] <= LIM) && (dy[i] >= -LIM);
            ssum[i] = 63'(sx_reg[i]) + 63'(sy_reg[i]);
            hit[i] = ok2_reg[i] && ((ssum[i] >> FRAC_BITS) < 63'(tol_sq));
        end
        // first match wins
        if (m2_reg.zero_den)
            color_next = COLOR_NONE;
        else if (hit[0])
            color_next = COLOR_ORIGIN;
        else if (hit[1])
            color_next = COLOR_UPPER;
        else if (hit[2])
            color_next = COLOR_LOWER;
        else if (hit[3])
            color_next = COLOR_ONE;
        else
            color_next = COLOR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_reg <= '0;
            m2_reg <= '0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_reg <= in_meta;
            m2_reg <= m1_reg;
            v3_reg <= m2_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ax_reg[i] <= dx[i][33] ? 31'(-dx[i]) : dx[i][30:0];
                ay_reg[i] <= dy[i][33] ? 31'(-dy[i]) : dy[i][30:0];
                sx_reg[i] <= 62'(ax_reg[i]) * 62'(ax_reg[i]);
                sy_reg[i] <= 62'(ay_reg[i]) * 62'(ay_reg[i]);
            end
            ok1_reg    <= ok_next;
            ok2_reg    <= ok1_reg;
            col3_reg   <= m2_reg.column;
            row3_reg   <= m2_reg.row;
            color3_reg <= color_next;
        end
    end

    assign out_valid  = v3_reg;
    assign out_column = col3_reg;
    assign out_row    = row3_reg;
    assign out_color  = color3_reg;

endmodule

[rtl/core/newton_fractal_pixel_classifier.sv]
// Top level: Newton fractal pixel classifier for the cube roots of unity.
//
//  channel   dir  payload (low bit first)                        handshake
//  s_axis    in   column[9:0] row[19:10] zero[23:20]            tvalid/tready
//  m_axis    out  pixel_column[9:0] pixel_row[19:10] color[22:20] tvalid/tready
//  cfg       in   cfg_index selects register, cfg_data           cfg_we, no wait
//
//  One word per cycle in and out while the output is not stalled; pipeline
//  depth is set by the 31-step restoring divider in each iteration.
//  Reset clears all valid bits and loads the default register values.
//  A result not taken holds the whole pipeline; s_axis_tready drops with it.
module newton_fractal_pixel_classifier #(
    parameter int ITERATIONS = 9,
    parameter int FRAC_BITS  = 24
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nfpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [nfpc_pkg::TDATA_W-1:0]      s_axis_tdata,   // column, row
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [nfpc_pkg::TDATA_W-1:0]      m_axis_tdata    // pixel_column, pixel_row, color
);
    import nfpc_pkg::*;

    logic signed [31:0] x_start_reg, y_start_reg;
    logic [30:0]        x_step_reg, y_step_reg, tol_sq_reg;

    logic       en;
    meta_t      in_meta;
    meta_t      meta [0:ITERATIONS];
    cplx_t      z    [0:ITERATIONS];
    logic [IDX_W-1:0] o_col, o_row;
    color_t     o_color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_start_reg <= -32'sd33554432;
            y_start_reg <= -32'sd33554432;
            x_step_reg  <= 31'd65601;
            y_step_reg  <= 31'd65601;
            tol_sq_reg  <= 31'd17;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_X_START: x_start_reg <= cfg_data;
                REG_Y_START: y_start_reg <= cfg_data;
                REG_X_STEP:  x_step_reg  <= cfg_data[30:0];
                REG_Y_STEP:  y_step_reg  <= cfg_data[30:0];
                REG_TOL_SQ:  tol_sq_reg  <= cfg_data[30:0];
                default:     ;
            endcase
        end
    end

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        in_meta          = '0;
        in_meta.valid    = s_axis_tvalid;
        in_meta.column   = s_axis_tdata[IDX_W-1:0];
        in_meta.row      = s_axis_tdata[2*IDX_W-1:IDX_W];
    end

    nfpc_start u_start
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_meta  (in_meta),
        .x_start  (x_start_reg),
        .y_start  (y_start_reg),
        .x_step   (x_step_reg),
        .y_step   (y_step_reg),
        .out_meta (meta[0]),
        .out_z    (z[0])
    );

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_iter
        nfpc_iter #(.FRAC_BITS(FRAC_BITS)) u_iter
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_meta  (meta[i]),
            .in_z     (z[i]),
            .out_meta (meta[i+1]),
            .out_z    (z[i+1])
        );
    end

    nfpc_class #(.FRAC_BITS(FRAC_BITS)) u_class
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_meta    (meta[ITERATIONS]),
        .in_z       (z[ITERATIONS]),
        .tol_sq     (tol_sq_reg),
        .out_valid  (m_axis_tvalid),
        .out_column (o_col),
        .out_row    (o_row),
        .out_color  (o_color)
    );

    assign m_axis_tdata = {1'b0, o_color, o_row, o_col};

endmodule

[rtl/core/nfpc_check.sv]
// Port-level checker for the classifier, bound to the top level.
module nfpc_check
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [nfpc_pkg::TDATA_W-1:0] m_axis_tdata
);
    import nfpc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[22:20] <= COLOR_ONE)
        else $error("color code out of range");

    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while pipeline is stalled");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind newton_fractal_pixel_classifier nfpc_check u_check (.*);

[verif/tb_top.sv]
// Testbench for the Newton fractal pixel classifier: scoreboard, stimulus and checking.
`timescale 1ns / 100ps

module tb_top;
    import nfpc_pkg::*;

    typedef logic signed [95:0] wide_t;

    typedef struct {
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
        color_t           color;
    } pixel_result_t;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int  FB         = 24;
    localparam int  LATENCY    = 5 + 42 * 9;
    localparam int  CYCLE_CAP  = 400000;
    localparam int  HOLD_LEN   = 1200;

    class pixel_scoreboard;
        int   x_start, y_start, x_step, y_step, tol_sq;
        int   errors;
        pixel_result_t expected_pixels[$];

        function new();
            x_start = -33554432;
            y_start = -33554432;
            x_step  = 65601;
            y_step  = 65601;
            tol_sq  = 17;
            errors  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
            case (idx)
                REG_X_START: x_start = v;
                REG_Y_START: y_start = v;
                REG_X_STEP:  x_step  = {1'b0, v[30:0]};
                REG_Y_STEP:  y_step  = {1'b0, v[30:0]};
                REG_TOL_SQ:  tol_sq  = {1'b0, v[30:0]};
                default: ;
            endcase
        endfunction

        function int clamp(wide_t v);
            if (v > wide_t'(32'sh7fffffff))
                return Q_MAX;
            if (v < wide_t'(Q_MIN))
                return Q_MIN;
            return int'(v[31:0]);
        endfunction

        // round half up, floor shift; left unsaturated
        function wide_t fx_mul(int a, int b);
            wide_t p;
            p = wide_t'(a) * wide_t'(b) + (wide_t'(1) <<< (FB - 1));
            return p >>> FB;
        endfunction

        function int fx_div(wide_t n, wide_t d);
            logic neg;
            wide_t mag, q;
            neg = n < 0;
            mag = neg ? -n : n;
            if (mag / d >= (wide_t'(1) <<< (31 - FB)))
                q = wide_t'(1) <<< 31;
            else
                q = (mag <<< FB) / d;
            return clamp(neg ? -q : q);
        endfunction

        function bit is_near(int zr, int zi, wide_t cr, wide_t ci);
            wide_t dx, dy, s;
            dx = wide_t'(zr) - cr;
            dy = wide_t'(zi) - ci;
            if (dx > 64'sd2147483647 || dx < -64'sd2147483647) return 0;
            if (dy > 64'sd2147483647 || dy < -64'sd2147483647) return 0;
            s = dx * dx + dy * dy;
            return (s >>> FB) < wide_t'(tol_sq);
        endfunction

        function color_t classify(logic [IDX_W-1:0] c, logic [IDX_W-1:0] r);
            int zr, zi, z2r, z2i, z3r, z3i, z4r, z4i, z6r, z6i, dr, di, qr, qi;
            wide_t den, half, sin60;
            bit zero_den;
            zero_den = 0;
            half  = wide_t'(1) <<< (FB - 1);
            sin60 = (wide_t'(SIN60_Q30) + ((wide_t'(1) <<< (30 - FB)) >>> 1)) >>> (30 - FB);
            zr = clamp(wide_t'(x_start) + wide_t'(c) * wide_t'(x_step));
            zi = clamp(wide_t'(y_start) + wide_t'(r) * wide_t'(y_step));
            for (int it = 0; it < 9; it++)
            begin
                z2r = clamp(fx_mul(zr, zr) - fx_mul(zi, zi));
                z2i = clamp(fx_mul(zr, zi) + fx_mul(zi, zr));
                z3r = clamp(fx_mul(z2r, zr) - fx_mul(z2i, zi));
                z3i = clamp(fx_mul(z2r, zi) + fx_mul(z2i, zr));
                z4r = clamp(fx_mul(z3r, zr) - fx_mul(z3i, zi));
                z4i = clamp(fx_mul(z3r, zi) + fx_mul(z3i, zr));
                z6r = clamp(fx_mul(z3r, z3r) - fx_mul(z3i, z3i));
                z6i = clamp(fx_mul(z3r, z3i) + fx_mul(z3i, z3r));
                dr = clamp(5 * wide_t'(z6r) + 2 * wide_t'(z3r) + (wide_t'(2) <<< FB));
                di = clamp(5 * wide_t'(z6i) + 2 * wide_t'(z3i));
                den = wide_t'(dr) * wide_t'(dr) + wide_t'(di) * wide_t'(di);
                if (den == 0)
                begin
                    zero_den = 1;
                    qr = Q_MAX;
                    qi = Q_MAX;
                end
                else
                begin
                    qr = fx_div(wide_t'(z4r) * wide_t'(dr) + wide_t'(z4i) * wide_t'(di), den);
                    qi = fx_div(wide_t'(z4i) * wide_t'(dr) - wide_t'(z4r) * wide_t'(di), den);
                end
                zr = clamp(9 * wide_t'(qr));
                zi = clamp(9 * wide_t'(qi));
            end
            if (zero_den)
                return COLOR_NONE;
            if (is_near(zr, zi, 0, 0))
                return COLOR_ORIGIN;
            if (is_near(zr, zi, -half, sin60))
                return COLOR_UPPER;
            if (is_near(zr, zi, -half, -sin60))
                return COLOR_LOWER;
            if (is_near(zr, zi, wide_t'(1) <<< FB, 0))
                return COLOR_ONE;
            return COLOR_NONE;
        endfunction

        function void note_pixel(logic [TDATA_W-1:0] word);
            pixel_result_t e;
            e.column = word[9:0];
            e.row    = word[19:10];
            e.color  = classify(e.column, e.row);
            expected_pixels.push_back(e);
        endfunction

        function void check_pixel(logic [TDATA_W-1:0] word);
            pixel_result_t e;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $time, word);
                errors++;
                return;
            end
            e = expected_pixels.pop_front();
            if (word[9:0] !== e.column)
            begin
                $display("%0t: column expected %0d actual %0d", $time, e.column, word[9:0]);
                errors++;
            end
            if (word[19:10] !== e.row)
            begin
                $display("%0t: row expected %0d actual %0d", $time, e.row, word[19:10]);
                errors++;
            end
            if (word[22:20] !== e.color)
            begin
                $display("%0t: color at (%0d,%0d) expected %0d actual %0d",
                         $time, e.column, e.row, e.color, word[22:20]);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [31:0]            cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [TDATA_W-1:0]     m_axis_tdata;

    pixel_scoreboard sb;
    bit  idle_on;
    bit  hold_request;
    int  hold_left;
    int  cycles;

    newton_fractal_pixel_classifier dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_axis_tready = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 0;
            end
            else
                m_axis_tready <= !(idle_on && $urandom_range(99) < 18);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_pixel(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata);
    end

    task automatic send_pixel(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
        if (idle_on)
            while ($urandom_range(99) < 18)
            begin
                s_axis_tvalid <= 0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {4'b0, row, col};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            send_pixel(IDX_W'($urandom_range(1023)), IDX_W'($urandom_range(1023)));
    endtask

    // only while idle: drain, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic write_regs(logic [31:0] xs, logic [31:0] ys, logic [31:0] xst,
                              logic [31:0] yst, logic [31:0] tol);
        logic [31:0] vals[6];
        logic [CFG_IDX_W-1:0] idxs[6];
        vals = '{xs, ys, xst, yst, tol, 32'hffffffff};
        idxs = '{REG_X_START, REG_Y_START, REG_X_STEP, REG_Y_STEP, REG_TOL_SQ,
                 CFG_UNUSED_IDX};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            sb.set_reg(idxs[i], vals[i]);
            @(posedge clk);
        end
        cfg_we <= 0;
        @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        idle_on = 0;
        hold_request = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // defaults: corners, center, extremes of the indices
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd767, 10'd512);
        send_pixel(10'd384, 10'd734);
        send_pixel(10'd384, 10'd290);
        send_pixel(10'h2aa, 10'h155);
        send_pixel(10'h155, 10'h2aa);
        send_random(150);
        idle_on = 1;
        send_random(150);
        hold_request = 1;
        send_random(500);
        drain();

        // saturating extremes
        write_regs(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_random(20);
        drain();
        write_regs(32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 32'h0);
        send_pixel(10'd0, 10'd0);
        send_random(10);
        drain();
        write_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h7fffffff);
        send_pixel(10'd1023, 10'd1023);
        drain();

        // zoomed region near the root boundaries, looser tolerance
        write_regs(-32'sd16777216, -32'sd16777216, 32'd32768, 32'd32768, 32'd1 << 20);
        send_random(150);
        drain();

        write_regs(-32'sd33554432 + $urandom_range(65535), -32'sd33554432,
                   32'd65601, 32'd65601, 32'd17);
        send_random(150);
        drain();

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
